// ===== rtl/imu_serial_frame_decoder_unit_assert.svh =====
// ---------------------------------------------------------------------------
// IMU frame decoder assertion macros
// Shared property forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef IMU_SERIAL_FRAME_DECODER_UNIT_ASSERT_SVH
`define IMU_SERIAL_FRAME_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ISFD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ISFD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/isfd_pkg.sv =====
// ---------------------------------------------------------------------------
// IMU frame decoder package
// Shared types, codes and constants of the frame decoder.
// ---------------------------------------------------------------------------
package isfd_pkg;

   localparam int BYTE_W      = 8;
   localparam int YAW_W       = 16;
   localparam int CSR_IDX_W   = 8;
   localparam int SCALE_MUL_W = 15;

   // Byte positions inside a frame.
   localparam int POS_TYPE     = 1;
   localparam int POS_YAW_LOW  = 6;
   localparam int POS_YAW_HIGH = 7;

   // Yaw scaling: floor(raw * 18000 / 32768) done on the offset value.
   localparam logic [SCALE_MUL_W-1:0] SCALE_MUL   = 15'd18000;
   localparam int                     SCALE_SHIFT = 15;
   localparam logic signed [YAW_W-1:0] SCALE_BIAS = 16'sd18000;

   localparam logic [BYTE_W-1:0] HEADER_RESET     = 8'h55;
   localparam logic [BYTE_W-1:0] ANGLE_TYPE_RESET = 8'h53;

   typedef enum logic [1:0] {
      STATUS_ANGLE_OK = 2'd0,
      STATUS_OTHER_OK = 2'd1,
      STATUS_CSUM_ERR = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEADER     = 8'd0,
      CSR_ANGLE_TYPE = 8'd1
   } csr_reg_type;

   typedef enum logic {
      ST_HUNT    = 1'b0,
      ST_COLLECT = 1'b1
   } fstate_type;

   typedef struct packed {
      logic [BYTE_W-1:0] header_value;
      logic [BYTE_W-1:0] angle_frame_type;
   } cfg_type;

   typedef struct packed {
      status_type               status;
      logic [BYTE_W-1:0]        frame_type;
      logic signed [YAW_W-1:0]  yaw_raw;
   } frame_rec_type;

endpackage

// ===== rtl/isfd_ifs.sv =====
// ---------------------------------------------------------------------------
// IMU frame decoder channel interfaces
// Valid/ready channels for bytes in, frame results out and register writes.
// ---------------------------------------------------------------------------
interface isfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface isfd_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         frame_status;
   logic [7:0]         frame_type;
   logic signed [15:0] yaw_raw;
   logic signed [15:0] yaw_centideg;
   modport source (output valid, output frame_status, output frame_type,
                   output yaw_raw, output yaw_centideg, input ready);
   modport sink   (input valid, input frame_status, input frame_type,
                   input yaw_raw, input yaw_centideg, output ready);
endinterface

interface isfd_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/imu_serial_frame_decoder_unit.sv =====
// ---------------------------------------------------------------------------
// IMU serial frame decoder: one byte per cycle in, one result per frame.
// A result passes from the record queue through the output register to rsp.
// Back-pressure on rsp stalls only the last byte of a frame, once two
// records wait. Reset clears the hunt FSM, queue and output valid.
// ---------------------------------------------------------------------------
module imu_serial_frame_decoder_unit #(
   parameter int FRAME_LEN = 11
) (
   input  logic        clock,
   input  logic        reset,
   isfd_req_if.sink    req_bus,
   isfd_rsp_if.source  rsp_bus,
   isfd_csr_if.sink    csr_bus
);
   import isfd_pkg::*;

   // Configuration registers; header_value is used while hunting,
   // angle_frame_type when a frame closes.
   cfg_type       cfg_ff;
   logic          csr_write;

   // Record queue between front and back.
   logic          q_push, q_pop, q_full, q_empty;
   frame_rec_type q_wr_data, q_rd_data;

   // Always take register writes; an unknown index is dropped.
   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_value     <= HEADER_RESET;
         cfg_ff.angle_frame_type <= ANGLE_TYPE_RESET;
      end else if (csr_write) begin
         case (csr_bus.index)
            CSR_HEADER:     cfg_ff.header_value     <= csr_bus.data;
            CSR_ANGLE_TYPE: cfg_ff.angle_frame_type <= csr_bus.data;
            default:        cfg_ff                  <= cfg_ff;
         endcase
      end
   end

   // Front: header hunt, byte count, checksum, record build.
   isfd_front #(
      .FRAME_LEN (FRAME_LEN)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .cfg     (cfg_ff),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_data  (q_wr_data)
   );

   // Decouple the byte stream from result back-pressure.
   isfd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .rd_data (q_rd_data)
   );

   // Back: yaw scaling multiply and the output register.
   isfd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (q_rd_data),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== rtl/isfd_front.sv =====
// ---------------------------------------------------------------------------
// IMU frame decoder front end
// Hunt for the header, collect a frame, check the sum and queue a record.
// ---------------------------------------------------------------------------
module isfd_front #(
   parameter int FRAME_LEN = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   isfd_req_if.sink               req_bus,
   input  isfd_pkg::cfg_type      cfg,
   input  logic                   q_full,
   output logic                   q_push,
   output isfd_pkg::frame_rec_type q_data
);
   import isfd_pkg::*;

   localparam int IdxW = $clog2(FRAME_LEN);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(FRAME_LEN - 1);

   fstate_type        state_ff, state_in;
   logic [IdxW-1:0]   idx_ff, idx_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] type_ff, yaw_low_ff, yaw_high_ff;
   logic              accept;
   logic              is_last;
   logic [BYTE_W-1:0] yaw_high_now;
   logic              hdr_hit;

   assign accept  = req_bus.valid && req_bus.ready;
   assign hdr_hit = (req_bus.rx_byte == cfg.header_value);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_HUNT: begin
            if (accept && hdr_hit) state_in = ST_COLLECT;
         end
         ST_COLLECT: begin
            if (accept && is_last) state_in = ST_HUNT;
         end
         default: state_in = ST_HUNT;
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      is_last       = 1'b0;
      req_bus.ready = 1'b1;
      case (state_ff)
         ST_HUNT: begin
            req_bus.ready = 1'b1;
         end
         ST_COLLECT: begin
            is_last       = (idx_ff == LastIdx);
            req_bus.ready = !is_last || !q_full;
         end
         default: begin
            req_bus.ready = 1'b1;
         end
      endcase
   end

   // Index and running sum.
   always_comb begin
      idx_in = idx_ff;
      sum_in = sum_ff;
      if (accept) begin
         if (state_ff == ST_HUNT) begin
            if (hdr_hit) begin
               idx_in = IdxW'(1);
               sum_in = req_bus.rx_byte;
            end
         end else if (is_last) begin
            idx_in = '0;
            sum_in = '0;
         end else begin
            idx_in = idx_ff + IdxW'(1);
            sum_in = sum_ff + req_bus.rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
         idx_ff   <= '0;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         sum_ff   <= sum_in;
      end
   end

   // Capture the type and yaw bytes.
   always_ff @(posedge clock) begin
      if (accept && state_ff == ST_COLLECT) begin
         if (idx_ff == IdxW'(POS_TYPE))     type_ff     <= req_bus.rx_byte;
         if (idx_ff == IdxW'(POS_YAW_LOW))  yaw_low_ff  <= req_bus.rx_byte;
         if (idx_ff == IdxW'(POS_YAW_HIGH)) yaw_high_ff <= req_bus.rx_byte;
      end
   end

   // On the shortest frame the checksum byte doubles as the yaw high byte.
   assign yaw_high_now = (idx_ff == IdxW'(POS_YAW_HIGH)) ? req_bus.rx_byte : yaw_high_ff;

   always_comb begin
      q_data.frame_type = type_ff;
      q_data.yaw_raw    = '0;
      if (sum_ff != req_bus.rx_byte) begin
         q_data.status = STATUS_CSUM_ERR;
      end else if (type_ff == cfg.angle_frame_type) begin
         q_data.status  = STATUS_ANGLE_OK;
         q_data.yaw_raw = signed'({yaw_high_now, yaw_low_ff});
      end else begin
         q_data.status = STATUS_OTHER_OK;
      end
   end

   assign q_push = accept && (state_ff == ST_COLLECT) && is_last;

endmodule

// ===== rtl/isfd_queue.sv =====
// ---------------------------------------------------------------------------
// IMU frame decoder record queue
// Two-entry queue of frame records between front and back end.
// ---------------------------------------------------------------------------
module isfd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  isfd_pkg::frame_rec_type wr_data,
   output logic                    full,
   input  logic                    pop,
   output logic                    empty,
   output isfd_pkg::frame_rec_type rd_data
);
   import isfd_pkg::*;

   frame_rec_type mem_ff [2];
   logic          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]    count_ff;
   logic          do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

// ===== rtl/isfd_back.sv =====
// ---------------------------------------------------------------------------
// IMU frame decoder back end
// Scale the yaw to centidegrees and hold the result in the output register.
// ---------------------------------------------------------------------------
module isfd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  isfd_pkg::frame_rec_type q_data,
   output logic                    q_pop,
   isfd_rsp_if.source              rsp_bus
);
   import isfd_pkg::*;

   logic                               valid_ff, valid_in;
   logic [1:0]                         status_ff;
   logic [BYTE_W-1:0]                  type_ff;
   logic signed [YAW_W-1:0]            raw_ff;
   logic signed [YAW_W-1:0]            cdeg_ff, cdeg_in;
   logic [YAW_W-1:0]                   biased;
   logic [YAW_W+SCALE_MUL_W-1:0]       prod;

   assign q_pop = !q_empty && (!valid_ff || rsp_bus.ready);

   // Offset raw by 32768 (flip the sign bit) so the floor is a plain shift.
   assign biased  = {~q_data.yaw_raw[YAW_W-1], q_data.yaw_raw[YAW_W-2:0]};
   assign prod    = biased * SCALE_MUL;
   assign cdeg_in = signed'(prod[SCALE_SHIFT +: YAW_W]) - SCALE_BIAS;

   always_comb begin
      valid_in = valid_ff;
      if (q_pop)              valid_in = 1'b1;
      else if (rsp_bus.ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         status_ff <= q_data.status;
         type_ff   <= q_data.frame_type;
         raw_ff    <= q_data.yaw_raw;
         cdeg_ff   <= cdeg_in;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.frame_status = status_ff;
   assign rsp_bus.frame_type   = type_ff;
   assign rsp_bus.yaw_raw      = raw_ff;
   assign rsp_bus.yaw_centideg = cdeg_ff;

endmodule

// ===== rtl/isfd_checker.sv =====
// ---------------------------------------------------------------------------
// IMU frame decoder port checker
// Port-level properties of the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "imu_serial_frame_decoder_unit_assert.svh"

module isfd_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_frame_status,
   input logic [7:0]         rsp_frame_type,
   input logic signed [15:0] rsp_yaw_raw,
   input logic signed [15:0] rsp_yaw_centideg
);
   import isfd_pkg::*;

   // Hold a stalled result.
   `ISFD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_frame_status) && $stable(rsp_frame_type) && $stable(rsp_yaw_raw) && $stable(rsp_yaw_centideg))

   // Never emit the unused status code.
   `ISFD_ASSERT_IMP(a_status_code, clock, reset, rsp_valid, rsp_frame_status == STATUS_ANGLE_OK || rsp_frame_status == STATUS_OTHER_OK || rsp_frame_status == STATUS_CSUM_ERR)

   // Drive yaw to zero unless the frame is a good angle frame.
   `ISFD_ASSERT_IMP(a_yaw_zero, clock, reset, rsp_valid && rsp_frame_status != STATUS_ANGLE_OK, rsp_yaw_raw == 16'sd0 && rsp_yaw_centideg == 16'sd0)

   // Flooring keeps the sign of the raw yaw.
   `ISFD_ASSERT_IMP(a_yaw_sign, clock, reset, rsp_valid, rsp_yaw_raw[15] == rsp_yaw_centideg[15])

endmodule

bind imu_serial_frame_decoder_unit isfd_checker u_isfd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_frame_status (rsp_bus.frame_status),
   .rsp_frame_type   (rsp_bus.frame_type),
   .rsp_yaw_raw      (rsp_bus.yaw_raw),
   .rsp_yaw_centideg (rsp_bus.yaw_centideg)
);

// ===== test/imu_serial_frame_decoder_unit_test.sv =====
// ---------------------------------------------------------------------------
// IMU serial frame decoder unit test
// Feeds serial bytes into the decoder: directed frames with hand-computed
// results first, then random frames, noise and cut-off frames under several
// header and angle-type settings. An internal decoder model predicts every
// frame result, which is checked in order against the rsp channel.
// ---------------------------------------------------------------------------
module imu_serial_frame_decoder_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import isfd_pkg::*;

   localparam int FRAME_LEN        = 11;
   localparam int FRAMES_PER_PHASE = 34;
   localparam int DRAIN_CYCLES     = 8;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int REPORT_LIMIT     = 10;

   // Indexes past the end of the register map; writes to them must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_PAST_END = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_IDX  = 8'hFF;

   typedef struct {
      status_type               status;
      logic [BYTE_W-1:0]        frame_type;
      logic signed [YAW_W-1:0]  yaw_raw;
      logic signed [YAW_W-1:0]  yaw_centideg;
   } frame_result_type;

   // One directed frame: a noise byte in front, then a full frame built from
   // these fields; csum_delta offsets the checksum byte to force an error.
   typedef struct packed {
      logic [7:0]         noise;
      logic [7:0]         ftype;
      logic [7:0]         ylo;
      logic [7:0]         yhi;
      logic [7:0]         fill;
      logic [7:0]         csum_delta;
      status_type         status;
      logic signed [15:0] yaw_raw;
      logic signed [15:0] yaw_centideg;
   } frame_row_type;

   localparam frame_row_type DIRECTED_FRAMES [4] = '{
      // most negative yaw of an angle frame
      '{8'h00, 8'h53, 8'h00, 8'h80, 8'h00, 8'h00, STATUS_ANGLE_OK, -16'sd32768, -16'sd18000},
      // most positive yaw, header value repeated inside the payload
      '{8'hFF, 8'h53, 8'hFF, 8'h7F, 8'h55, 8'h00, STATUS_ANGLE_OK, 16'sd32767, 16'sd17999},
      // other frame type: yaw forced to zero
      '{8'hAA, 8'h51, 8'hFF, 8'hFF, 8'hFF, 8'h00, STATUS_OTHER_OK, 16'sd0, 16'sd0},
      // bad checksum on an angle frame: yaw forced to zero
      '{8'h54, 8'h53, 8'h34, 8'h12, 8'hA5, 8'h01, STATUS_CSUM_ERR, 16'sd0, 16'sd0}
   };

   logic clock = 1'b0;
   logic reset;

   isfd_req_if req_bus ();
   isfd_rsp_if rsp_bus ();
   isfd_csr_if csr_bus ();

   imu_serial_frame_decoder_unit #(
      .FRAME_LEN (FRAME_LEN)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #2 clock = ~clock;

   // Decoder model state, mirrors the block's registers.
   cfg_type           cfg_now = '{header_value: HEADER_RESET, angle_frame_type: ANGLE_TYPE_RESET};
   fstate_type        frame_state = ST_HUNT;
   int                next_pos = 0;
   logic [BYTE_W-1:0] csum_acc = '0;
   logic [BYTE_W-1:0] type_seen = '0;
   logic [BYTE_W-1:0] yaw_lo_seen = '0;
   logic [BYTE_W-1:0] yaw_hi_seen = '0;

   frame_result_type pending_frames[$];  // results still owed by the block
   frame_result_type known_results[$];   // hand-computed results of directed frames

   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  tx_idle_pct = 30;
   int  rx_stall_pct = 52;
   bit  rsp_hold_request = 1'b0;
   int  rsp_hold_left = 0;

   // Advance the model by one accepted byte; queue a result at frame end.
   function automatic void decode_byte(input logic [BYTE_W-1:0] b);
      frame_result_type res;
      int               yaw;
      int               scaled;
      if (frame_state == ST_HUNT) begin
         // drop everything until the header shows up
         if (b == cfg_now.header_value) begin
            frame_state = ST_COLLECT;
            next_pos = 1;
            csum_acc = b;
         end
         return;
      end
      case (next_pos)
         POS_TYPE:     type_seen = b;
         POS_YAW_LOW:  yaw_lo_seen = b;
         POS_YAW_HIGH: yaw_hi_seen = b;
         default: ;
      endcase
      if (next_pos < FRAME_LEN - 1) begin
         csum_acc = csum_acc + b;
         next_pos = next_pos + 1;
         return;
      end
      // last byte is the checksum; classify and emit
      if (csum_acc != b) begin
         res.status = STATUS_CSUM_ERR;
      end else if (type_seen == cfg_now.angle_frame_type) begin
         res.status = STATUS_ANGLE_OK;
      end else begin
         res.status = STATUS_OTHER_OK;
      end
      res.frame_type = type_seen;
      res.yaw_raw = '0;
      res.yaw_centideg = '0;
      if (res.status == STATUS_ANGLE_OK) begin
         yaw = $signed({yaw_hi_seen, yaw_lo_seen});
         // arithmetic shift of the signed product floors toward minus infinity
         scaled = (yaw * 18000) >>> 15;
         res.yaw_raw = yaw[15:0];
         res.yaw_centideg = scaled[15:0];
      end
      // directed frames carry their own typed-in result
      if (known_results.size() != 0) begin
         res = known_results.pop_front();
      end
      pending_frames.push_back(res);
      frame_state = ST_HUNT;
      next_pos = 0;
      csum_acc = '0;
   endfunction

   // Compare one accepted result against the oldest owed result.
   function automatic void check_frame_result();
      frame_result_type want;
      if (pending_frames.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("unexpected result: status %0d type %h yaw %0d centideg %0d",
                     rsp_bus.frame_status, rsp_bus.frame_type, rsp_bus.yaw_raw,
                     rsp_bus.yaw_centideg);
         end
         return;
      end
      want = pending_frames.pop_front();
      if (rsp_bus.frame_status !== want.status || rsp_bus.frame_type !== want.frame_type ||
          rsp_bus.yaw_raw !== want.yaw_raw || rsp_bus.yaw_centideg !== want.yaw_centideg) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch: expected status %0d type %h yaw %0d centideg %0d",
                     want.status, want.frame_type, want.yaw_raw, want.yaw_centideg);
            $display("          actual   status %0d type %h yaw %0d centideg %0d",
                     rsp_bus.frame_status, rsp_bus.frame_type, rsp_bus.yaw_raw,
                     rsp_bus.yaw_centideg);
         end
      end
   endfunction

   // Observe all three channels on the pre-edge values. Check results before
   // decoding this edge's byte so an owed result is never jumped by a new one.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_HEADER:     cfg_now.header_value = csr_bus.data;
               CSR_ANGLE_TYPE: cfg_now.angle_frame_type = csr_bus.data;
               default: ;  // unmapped index: drop the write
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_frame_result();
         end
         if (req_bus.valid && req_bus.ready) begin
            decode_byte(req_bus.rx_byte);
         end
      end
   end

   // Result receiver: random stalls, plus one long hold on request so the
   // block's result queue fills and it must stall the byte input.
   always @(posedge clock) begin
      if (rsp_hold_request) begin
         rsp_hold_left = LONG_HOLD_CYCLES;
         rsp_hold_request = 1'b0;
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_frames.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Offer one byte, with a random gap in front, and hold it until accepted.
   task automatic send_byte(input logic [7:0] b);
      if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Send the first len bytes of a frame; the checksum byte is the running
   // sum plus csum_delta. The checksum slot wins over the yaw-high slot.
   task automatic send_frame(input logic [7:0] hdr, input logic [7:0] ftype,
                             input logic [7:0] ylo, input logic [7:0] yhi,
                             input logic [7:0] fill, input bit rand_fill,
                             input logic [7:0] csum_delta, input int len);
      logic [7:0] b;
      logic [7:0] sum;
      sum = '0;
      for (int i = 0; i < len; i++) begin
         if (i == 0) begin
            b = hdr;
         end else if (i == FRAME_LEN - 1) begin
            b = sum + csum_delta;
         end else if (i == POS_TYPE) begin
            b = ftype;
         end else if (i == POS_YAW_LOW) begin
            b = ylo;
         end else if (i == POS_YAW_HIGH) begin
            b = yhi;
         end else begin
            b = rand_fill ? 8'($urandom_range(255)) : fill;
         end
         sum = sum + b;
         send_byte(b);
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every owed result is in, then let trailing bytes settle.
   task automatic wait_drained();
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One setting of the registers, then a run of random frames. Most frames
   // are well formed; some have a bad checksum, some are cut short, and
   // noise bytes sit between them.
   task automatic run_phase(input logic [7:0] hdr, input logic [7:0] angle,
                            input int tx_pct, input int rx_pct, input bit long_hold);
      logic [7:0] noise;
      logic [7:0] ftype;
      logic [15:0] yaw;
      logic [7:0] delta;
      int          len;
      write_csr(CSR_HEADER, hdr);
      write_csr(CSR_ANGLE_TYPE, angle);
      tx_idle_pct = tx_pct;
      rx_stall_pct = rx_pct;
      for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
         if (long_hold && f == 4) begin
            rsp_hold_request = 1'b1;
         end
         repeat ($urandom_range(2)) begin
            noise = 8'($urandom_range(255));
            // keep most noise off the header so frames stay aligned
            if (noise == hdr && $urandom_range(99) < 80) begin
               noise = noise ^ 8'h01;
            end
            send_byte(noise);
         end
         ftype = ($urandom_range(1) == 0) ? angle : 8'($urandom_range(255));
         if ($urandom_range(99) < 10) begin
            case ($urandom_range(3))
               0: yaw = 16'h8000;
               1: yaw = 16'h7FFF;
               2: yaw = 16'hFFFF;
               default: yaw = 16'h0000;
            endcase
         end else begin
            yaw = 16'($urandom_range(65535));
         end
         delta = ($urandom_range(99) < 15) ? 8'($urandom_range(255, 1)) : 8'h00;
         len = ($urandom_range(99) < 5) ? $urandom_range(FRAME_LEN - 1, 1) : FRAME_LEN;
         send_frame(hdr, ftype, yaw[7:0], yaw[15:8], 8'h00, 1'b1, delta, len);
      end
      req_bus.valid <= 1'b0;
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.rx_byte = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Writes past the register map must leave the reset settings intact;
      // the directed frames below rely on them.
      write_csr(CSR_PAST_END, 8'h00);
      write_csr(CSR_TOP_IDX, 8'h00);

      // Directed frames under reset settings, results typed in.
      foreach (DIRECTED_FRAMES[r]) begin
         send_byte(DIRECTED_FRAMES[r].noise);
         known_results.push_back('{DIRECTED_FRAMES[r].status, DIRECTED_FRAMES[r].ftype,
                                   DIRECTED_FRAMES[r].yaw_raw,
                                   DIRECTED_FRAMES[r].yaw_centideg});
         send_frame(HEADER_RESET, DIRECTED_FRAMES[r].ftype, DIRECTED_FRAMES[r].ylo,
                    DIRECTED_FRAMES[r].yhi, DIRECTED_FRAMES[r].fill, 1'b0,
                    DIRECTED_FRAMES[r].csum_delta, FRAME_LEN);
      end
      req_bus.valid <= 1'b0;
      wait_drained();

      // Random phases: receiver-heavy idling, sender-heavy idling, then none,
      // with the long receiver hold in the third phase.
      run_phase(HEADER_RESET, ANGLE_TYPE_RESET, 30, 52, 1'b0);
      run_phase(8'h00, 8'hFF, 52, 30, 1'b0);
      run_phase(8'hFF, 8'h00, 0, 0, 1'b1);
      run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 0, 0, 1'b0);

      if (mismatch_count == 0 && pending_frames.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/isfd_pkg.sv
rtl/isfd_ifs.sv
rtl/isfd_front.sv
rtl/isfd_queue.sv
rtl/isfd_back.sv
rtl/imu_serial_frame_decoder_unit.sv
rtl/isfd_checker.sv
test/imu_serial_frame_decoder_unit_test.sv
